### rtl/core/contiguous_slot_allocator_assert.svh
// ----------------------------------------------------------------------------
// contiguous slot allocator assertion macros
// Clocked assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_SLOT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define CSA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CSA_ASSERT(label, clk, rst, prop, msg)
`define CSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/core/csa_pkg.sv
// ----------------------------------------------------------------------------
// csa_pkg
// Request and result types and codes of the contiguous slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package csa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  localparam logic [5:0] SLOTS_IN_USE_RST = 6'd32;

  typedef struct packed {
    opcode_t     opcode;
    logic [5:0]  run_length;
    logic [4:0]  start_slot;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  granted_slot;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/contiguous_slot_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_slot_allocator
// First-fit allocator of contiguous runs over an occupancy bitmap.
// ----------------------------------------------------------------------------
// Requests enter on req/req_valid and are taken at an edge where req_stall is
// low: allocate a run, free a run, or clear every slot. Each request gives one
// result on rsp/rsp_valid, held until an edge where rsp_stall is low.
// cfg_wr_en/cfg_wr_data set the number of usable slots; write it only while
// no request is in flight.
// A request taken at one edge is held in the request register, searched
// against the map while pending, and its result is then captured in the
// result register. One request per cycle is sustained while rsp_stall is
// low; the rate is set by the read-modify-write of the occupancy map, which
// each request updates before the next one is searched.
// All start windows are checked in parallel and the lowest free one wins.
// Reset empties the map, sets 32 usable slots and drops any pending request
// or result. While rsp_stall holds a result, at most one more request is
// registered and then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contiguous_slot_allocator_assert.svh"

module contiguous_slot_allocator
  import csa_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output rsp_t            rsp
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [5:0]            slots_in_use;
  logic [SLOT_COUNT-1:0] occupied_map;
  logic [SLOT_COUNT-1:0] occupied_map_next;
  logic                  pend_valid;
  req_t                  pend;
  rsp_t                  rsp_next;

  logic                  fire;
  logic                  take;
  logic [6:0]            usable;
  logic [6:0]            len7;
  logic [6:0]            end7;
  logic [SLOT_COUNT-1:0] len_mask;
  logic [SLOT_COUNT-1:0] use_mask;
  logic [SLOT_COUNT-1:0] free_map;
  logic [SLOT_COUNT-1:0] fits;
  logic [SLOT_COUNT-1:0] alloc_mask;
  logic [SLOT_COUNT-1:0] free_mask;
  logic                  found;
  logic [IW-1:0]         first;
  logic                  len_ok;
  logic                  free_ok;

  // handshake
  assign fire      = pend_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = pend_valid && !fire;
  assign take      = req_valid && !req_stall;

  // usable slot count, clipped to the map size
  assign usable = ({1'b0, slots_in_use} > 7'(SLOT_COUNT)) ? 7'(SLOT_COUNT)
                                                          : {1'b0, slots_in_use};
  assign len7   = {1'b0, pend.run_length};
  assign end7   = {2'b00, pend.start_slot} + len7;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_bit
    assign len_mask[i] = (7'(i) < len7);
    assign use_mask[i] = (7'(i) < usable);
  end

  assign free_map = ~occupied_map & use_mask;

  // window starting at each slot is free and inside the usable range
  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_win
    assign fits[s] = ((free_map >> s) & len_mask) == len_mask;
  end

  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (fits[i]) begin
        found = 1'b1;
        first = IW'(i);
      end
    end
  end

  assign len_ok     = (len7 != 7'd0) && (len7 <= usable);
  assign alloc_mask = len_mask << first;
  assign free_mask  = len_mask << pend.start_slot;
  assign free_ok    = (len7 != 7'd0) && (end7 <= usable) &&
                      ((occupied_map & free_mask) == free_mask);

  always_comb begin
    occupied_map_next     = occupied_map;
    rsp_next.status       = ST_BAD;
    rsp_next.granted_slot = '0;
    case (pend.opcode)
      OP_ALLOC: begin
        if (len7 == 7'd0) begin
          rsp_next.status = ST_BAD;
        end else if (len_ok && found) begin
          occupied_map_next     = occupied_map | alloc_mask;
          rsp_next.status       = ST_OK;
          rsp_next.granted_slot = 5'(first);
        end else begin
          rsp_next.status = ST_NO_SPACE;
        end
      end
      OP_FREE: begin
        if (free_ok) begin
          occupied_map_next = occupied_map & ~free_mask;
          rsp_next.status   = ST_OK;
        end
      end
      OP_CLEAR: begin
        occupied_map_next = '0;
        rsp_next.status   = ST_OK;
      end
      default: begin
        rsp_next.status = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
    end else if (cfg_wr_en) begin
      slots_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_map <= '0;
    end else if (fire) begin
      occupied_map <= occupied_map_next;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (take) begin
      pend_valid <= 1'b1;
    end else if (fire) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend <= req;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  `CSA_ASSERT_NEXT(a_clear_empties, clk, rst, fire && (pend.opcode == OP_CLEAR),
    occupied_map == '0, "clear request left slots occupied")

  `CSA_ASSERT_NEXT(a_no_grant_beyond_usable, clk, rst, fire,
    (occupied_map & ~$past(occupied_map) & ~$past(use_mask)) == '0,
    "slot outside the usable range was marked occupied")

  `CSA_ASSERT_IMPL(a_granted_zero_on_fail, clk, rst, rsp_valid && (rsp.status != ST_OK),
    rsp.granted_slot == '0, "granted slot not zero on a failed request")

  `CSA_ASSERT_NEXT(a_pending_held, clk, rst, pend_valid && !fire,
    pend_valid && $stable(pend), "pending request lost while blocked")

endmodule

`default_nettype wire

### dv/contiguous_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// contiguous_slot_allocator_tb
// Self-checking bench for the first-fit contiguous slot allocator. A short
// table of directed requests covers empty and full maps, zero and oversized
// runs, bad frees and the unknown opcode. Random phases then follow at several
// usable-slot counts, the extremes among them. Most frees hand back runs that
// were granted earlier. Each result is checked against its fixed row or a local
// model of the occupancy map, and both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module contiguous_slot_allocator_tb;
  import csa_pkg::*;

  localparam opcode_t OP_UNKNOWN = opcode_t'(2'd3);
  localparam int PHASE_ITEMS = 72;
  localparam int N_PHASES = 9;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t want;
  } dir_row_t;

  typedef struct {
    logic [4:0] start;
    logic [5:0] len;
  } run_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;
  logic       req_valid;
  logic       req_stall;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_stall;
  rsp_t       rsp;

  logic [31:0] slot_map;
  logic [5:0]  usable_cfg;
  rsp_t        outcome_q[$];
  run_t        live_runs[$];
  rsp_t        head_rsp;
  bit          idle_en;
  int          stall_left;
  int          mismatches;
  int          cycle_count;

  contiguous_slot_allocator DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // first fit allocation, frees and clears over the usable slots, updates the local map
  function automatic rsp_t allocator_outcome(req_t r);
    rsp_t        o;
    int          usable;
    int          s;
    bit          found;
    logic [63:0] m;
    o.status = ST_BAD;
    o.granted_slot = '0;
    usable = (usable_cfg > 6'd32) ? 32 : int'(usable_cfg);
    case (r.opcode)
      OP_ALLOC: begin
        if (r.run_length != 0) begin
          o.status = ST_NO_SPACE;
          found = 1'b0;
          for (s = 0; !found && s + int'(r.run_length) <= usable; s++) begin
            m = ((64'd1 << r.run_length) - 64'd1) << s;
            if ((slot_map & m[31:0]) == 32'd0) begin
              slot_map = slot_map | m[31:0];
              o.status = ST_OK;
              o.granted_slot = s[4:0];
              found = 1'b1;
            end
          end
        end
      end
      OP_FREE: begin
        if (r.run_length != 0 && int'(r.start_slot) + int'(r.run_length) <= usable) begin
          m = ((64'd1 << r.run_length) - 64'd1) << r.start_slot;
          if ((slot_map & m[31:0]) == m[31:0]) begin
            slot_map = slot_map & ~m[31:0];
            o.status = ST_OK;
          end
        end
      end
      OP_CLEAR: begin
        slot_map = '0;
        o.status = ST_OK;
      end
      default: o.status = ST_BAD;
    endcase
    return o;
  endfunction

  function automatic dir_row_t row(opcode_t op, int len, int st, bit fixed,
                                   status_t s, int g);
    dir_row_t d;
    d.r.opcode = op;
    d.r.run_length = len[5:0];
    d.r.start_slot = st[4:0];
    d.fixed = fixed;
    d.want.status = s;
    d.want.granted_slot = g[4:0];
    return d;
  endfunction

  task automatic issue_request(req_t r, bit fixed, rsp_t want);
    rsp_t got;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    got = allocator_outcome(r);
    outcome_q.push_back(fixed ? want : got);
    if (r.opcode == OP_ALLOC && got.status == ST_OK)
      live_runs.push_back('{got.granted_slot, r.run_length});
    else if (r.opcode == OP_CLEAR)
      live_runs.delete();
  endtask

  task automatic pick_request(output req_t r);
    int p;
    int idx;
    p = $urandom_range(0, 99);
    r.start_slot = 5'($urandom);
    r.run_length = 6'($urandom_range(1, 6));
    if (p < 55) begin
      r.opcode = OP_ALLOC;
      p = $urandom_range(0, 99);
      if (p < 12) r.run_length = 6'($urandom_range(7, 32));
      else if (p < 16) r.run_length = 6'($urandom_range(33, 63));
      else if (p < 19) r.run_length = 6'd0;
    end else if (p < 88) begin
      r.opcode = OP_FREE;
      if (live_runs.size() != 0 && $urandom_range(0, 9) < 8) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        r.start_slot = live_runs[idx].start;
        r.run_length = live_runs[idx].len;
        live_runs.delete(idx);
      end else if ($urandom_range(0, 3) == 0) begin
        r.run_length = 6'($urandom);
      end
    end else if (p < 92) begin
      r.opcode = OP_CLEAR;
      r.run_length = 6'($urandom);
    end else if (p < 95) begin
      r.opcode = OP_UNKNOWN;
      r.run_length = 6'($urandom);
    end else begin
      r.opcode = OP_ALLOC;
      r.run_length = 6'($urandom_range(10, 32));
    end
  endtask

  task automatic wait_quiet();
    req_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slots(logic [5:0] v);
    wait_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    usable_cfg = v;
    repeat (2) @(posedge clk);
  endtask

  // result checking and receiver stall bursts
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, got status %0d slot %0d",
                 $time, rsp.status, rsp.granted_slot);
      end else begin
        head_rsp = outcome_q.pop_front();
        if (rsp.status != head_rsp.status) begin
          mismatches++;
          $display("%0t: status expected %0d, got %0d",
                   $time, head_rsp.status, rsp.status);
        end
        if (rsp.granted_slot != head_rsp.granted_slot) begin
          mismatches++;
          $display("%0t: granted_slot expected %0d, got %0d",
                   $time, head_rsp.granted_slot, rsp.granted_slot);
        end
      end
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      rsp_stall <= 1'b1;
      stall_left = $urandom_range(0, 7);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dir_row_t   dir_rows[25];
    logic [5:0] phase_cfg[N_PHASES];
    req_t       r;
    rsp_t       none;
    int         i;
    int         ph;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    slot_map = '0;
    usable_cfg = SLOTS_IN_USE_RST;
    idle_en = 1'b1;
    stall_left = 0;
    mismatches = 0;
    cycle_count = 0;
    none = '0;

    dir_rows[0]  = row(OP_ALLOC,   0,  0, 1, ST_BAD,       0);
    dir_rows[1]  = row(OP_ALLOC,   63, 0, 1, ST_NO_SPACE,  0);
    dir_rows[2]  = row(OP_ALLOC,   33, 0, 1, ST_NO_SPACE,  0);
    dir_rows[3]  = row(OP_ALLOC,   32, 0, 1, ST_OK,        0);
    dir_rows[4]  = row(OP_ALLOC,   1,  0, 1, ST_NO_SPACE,  0);
    dir_rows[5]  = row(OP_FREE,    32, 0, 1, ST_OK,        0);
    dir_rows[6]  = row(OP_FREE,    1,  0, 1, ST_BAD,       0);
    dir_rows[7]  = row(OP_FREE,    0,  5, 1, ST_BAD,       0);
    dir_rows[8]  = row(OP_FREE,    2, 31, 1, ST_BAD,       0);
    dir_rows[9]  = row(OP_FREE,    63, 31, 1, ST_BAD,      0);
    dir_rows[10] = row(OP_UNKNOWN, 63, 31, 1, ST_BAD,      0);
    dir_rows[11] = row(OP_ALLOC,   1, 31, 1, ST_OK,        0);
    dir_rows[12] = row(OP_ALLOC,   3,  0, 0, ST_OK,        0);
    dir_rows[13] = row(OP_ALLOC,   2,  0, 0, ST_OK,        0);
    dir_rows[14] = row(OP_FREE,    3,  1, 0, ST_OK,        0);
    dir_rows[15] = row(OP_ALLOC,   2,  0, 0, ST_OK,        0);
    dir_rows[16] = row(OP_ALLOC,   2,  0, 0, ST_OK,        0);
    dir_rows[17] = row(OP_FREE,    4,  0, 0, ST_OK,        0);
    dir_rows[18] = row(OP_ALLOC,   1,  0, 0, ST_OK,        0);
    dir_rows[19] = row(OP_FREE,    1, 31, 0, ST_OK,        0);
    dir_rows[20] = row(OP_ALLOC,   24, 0, 0, ST_OK,        0);
    dir_rows[21] = row(OP_FREE,    24, 8, 0, ST_OK,        0);
    dir_rows[22] = row(OP_CLEAR,   63, 31, 1, ST_OK,       0);
    dir_rows[23] = row(OP_ALLOC,   31, 31, 1, ST_OK,       0);
    dir_rows[24] = row(OP_ALLOC,   1,  0, 1, ST_OK,       31);

    // shrinking without a clear leaves high slots marked
    phase_cfg = '{6'd63, 6'd1, 6'd0, 6'd17, 6'd33, 6'($urandom_range(2, 31)),
                  6'd8, 6'd32, 6'd32};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k])
      issue_request(dir_rows[k].r, dir_rows[k].fixed, dir_rows[k].want);

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_slots(phase_cfg[ph]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == N_PHASES - 1 && i >= PHASE_ITEMS / 3)
          idle_en = 1'b0;
        if (ph == 3 && i == PHASE_ITEMS / 2)
          wait_quiet();
        pick_request(r);
        issue_request(r, 1'b0, none);
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
